// ===== rtl/core/frm_pkg.sv =====
`timescale 1ns / 1ps

package frm_pkg;

  localparam int unsigned PIX_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned MODE_W     = 3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_COPY   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ROT90  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROT180 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROT270 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MIR_H  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MIR_V  = 3'd5;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 9'd256;

  typedef struct packed {
    logic wr;        // store pixel, advance write position
    logic rd_issue;  // latch read address, advance read position
    logic rd_mem;    // read frame store at latched address
  } cmd_t;

endpackage

// ===== rtl/core/frm_ctrl.sv =====
`timescale 1ns / 1ps

module frm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          req_type_i,
  output frm_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          valid_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   valid_q;
  logic   accept;

  assign accept = start_i && !busy_q;

  always_comb begin
    cmd_o.wr       = accept && (req_type_i == frm_pkg::REQ_WRITE);
    cmd_o.rd_issue = accept && (req_type_i == frm_pkg::REQ_READ);
    cmd_o.rd_mem   = (state_q == ST_RD);
  end

  always_comb begin
    state_d = ST_IDLE;
    case (state_q)
      ST_IDLE, ST_OUT: begin
        if (accept && (req_type_i == frm_pkg::REQ_READ)) begin
          state_d = ST_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        state_d = ST_OUT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d == ST_RD);
      valid_q <= (state_d == ST_OUT);
    end
  end

  assign busy_o  = busy_q;
  assign valid_o = valid_q;

  a_busy_then_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> valid_q)
    else $error("read fetch not followed by result strobe");

  a_valid_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(busy_q))
    else $error("result strobe without preceding fetch");

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.rd_mem && (cmd_o.wr || cmd_o.rd_issue)))
    else $error("item accepted during frame store fetch");

endmodule

// ===== rtl/core/frm_datapath.sv =====
`timescale 1ns / 1ps

module frm_datapath #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  frm_pkg::cmd_t                  cmd_i,
  input  logic [frm_pkg::PIX_W-1:0]      pixel_in_i,
  input  logic                           cfg_we_i,
  input  logic [frm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [frm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [frm_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                           frame_last_o
);

  localparam int unsigned MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DDW     = $clog2(MAX_DIM + 1);
  localparam int unsigned CW      = $clog2(MAX_WIDTH);
  localparam int unsigned RW      = $clog2(MAX_HEIGHT);
  localparam int unsigned OCW     = $clog2(MAX_DIM);
  localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW      = $clog2(DEPTH);

  logic [frm_pkg::MODE_W-1:0]     mode_q;
  logic [frm_pkg::CFG_DATA_W-1:0] width_q;
  logic [frm_pkg::CFG_DATA_W-1:0] height_q;

  logic [CW-1:0]  wr_col_q;
  logic [RW-1:0]  wr_row_q;
  logic [OCW-1:0] rd_col_q;
  logic [OCW-1:0] rd_row_q;

  logic [AW-1:0]  rd_addr_q;
  logic           last_q;
  logic [frm_pkg::PIX_W-1:0] rdata_q;
  logic [frm_pkg::PIX_W-1:0] mem_q [DEPTH];

  logic [DDW-1:0] w, h, ow, oh;
  logic [DDW-1:0] r, c, sr, sc;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr_d;
  logic           cfg_hit;
  logic           wr_col_end, wr_row_end;
  logic           rd_col_end, rd_row_end;

  // effective geometry, zero treated as one, saturated at the maximum
  always_comb begin
    if (width_q == '0) begin
      w = DDW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w = DDW'(MAX_WIDTH);
    end else begin
      w = DDW'(width_q);
    end
    if (height_q == '0) begin
      h = DDW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h = DDW'(MAX_HEIGHT);
    end else begin
      h = DDW'(height_q);
    end
    if (mode_q inside {frm_pkg::MODE_ROT90, frm_pkg::MODE_ROT270}) begin
      ow = h;
      oh = w;
    end else begin
      ow = w;
      oh = h;
    end
  end

  // source position of the current output pixel
  always_comb begin
    r = DDW'(rd_row_q);
    c = DDW'(rd_col_q);
    case (mode_q)
      frm_pkg::MODE_ROT90: begin
        sr = c;
        sc = w - DDW'(1) - r;
      end
      frm_pkg::MODE_ROT180: begin
        sr = h - DDW'(1) - r;
        sc = w - DDW'(1) - c;
      end
      frm_pkg::MODE_ROT270: begin
        sr = h - DDW'(1) - c;
        sc = r;
      end
      frm_pkg::MODE_MIR_H: begin
        sr = r;
        sc = w - DDW'(1) - c;
      end
      frm_pkg::MODE_MIR_V: begin
        sr = h - DDW'(1) - r;
        sc = c;
      end
      default: begin
        sr = r;
        sc = c;
      end
    endcase
  end

  assign rd_addr_d  = AW'(32'(sr) * MAX_WIDTH + 32'(sc));
  assign wr_addr    = AW'(32'(wr_row_q) * MAX_WIDTH + 32'(wr_col_q));
  assign wr_col_end = (DDW'(wr_col_q) == w - DDW'(1));
  assign wr_row_end = (DDW'(wr_row_q) == h - DDW'(1));
  assign rd_col_end = (c == ow - DDW'(1));
  assign rd_row_end = (r == oh - DDW'(1));

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_idx_i)
      frm_pkg::REG_MODE, frm_pkg::REG_WIDTH, frm_pkg::REG_HEIGHT: begin
        cfg_hit = cfg_we_i;
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= frm_pkg::MODE_COPY;
      width_q  <= frm_pkg::DIM_RESET;
      height_q <= frm_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        frm_pkg::REG_MODE:   mode_q   <= cfg_data_i[frm_pkg::MODE_W-1:0];
        frm_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        frm_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_col_q <= '0;
      wr_row_q <= '0;
      rd_col_q <= '0;
      rd_row_q <= '0;
    end else if (cfg_hit) begin
      wr_col_q <= '0;
      wr_row_q <= '0;
      rd_col_q <= '0;
      rd_row_q <= '0;
    end else begin
      if (cmd_i.wr) begin
        if (wr_col_end) begin
          wr_col_q <= '0;
          wr_row_q <= wr_row_end ? '0 : wr_row_q + RW'(1);
        end else begin
          wr_col_q <= wr_col_q + CW'(1);
        end
      end
      if (cmd_i.rd_issue) begin
        if (rd_col_end) begin
          rd_col_q <= '0;
          rd_row_q <= rd_row_end ? '0 : rd_row_q + OCW'(1);
        end else begin
          rd_col_q <= rd_col_q + OCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_addr_q <= rd_addr_d;
      last_q    <= rd_col_end && rd_row_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[wr_addr] <= pixel_in_i;
    end
    if (cmd_i.rd_mem) begin
      rdata_q <= mem_q[rd_addr_q];
    end
  end

  assign pixel_out_o  = rdata_q;
  assign frame_last_o = last_q;

endmodule

// ===== rtl/core/frame_rotate_mirror_top.sv =====
`timescale 1ns / 1ps

// frame_rotate_mirror_top: rotate / mirror transform over a frame store
// input channel: start_i with req_type_i and pixel_in_i, taken at a clock
//   edge where start_i is high and busy_o is low
// a write item stores pixel_in_i at the next source raster position and
//   gives no result
// a read item gives one result: pixel_out_o and frame_last_o, shown for one
//   cycle with valid_o high, in the cycle after the frame store fetch
// a read holds busy_o high for one cycle while the frame store is fetched,
//   when no new item is taken; writes run at one per cycle while busy_o is low;
//   a new item may be taken in the cycle its predecessor's result is shown
// config: cfg_we_i, cfg_idx_i, cfg_data_i write mode, width or height and
//   restart both raster positions; write only while idle
// reset clears control state and positions, mode copy, size 256 x 256;
//   the frame store is not cleared and must be written before it is read
// results cannot be stalled by the receiver

module frame_rotate_mirror_top #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           req_type_i,
  input  logic [frm_pkg::PIX_W-1:0]      pixel_in_i,
  output logic                           valid_o,
  output logic [frm_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                           frame_last_o,
  input  logic                           cfg_we_i,
  input  logic [frm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [frm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  frm_pkg::cmd_t cmd;

  frm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .cmd_o      (cmd),
    .busy_o     (busy_o),
    .valid_o    (valid_o)
  );

  frm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .pixel_in_i   (pixel_in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_W      = 256;
  localparam int unsigned MAX_H      = 256;
  localparam int unsigned STORE_SIZE = MAX_W * MAX_H;

  localparam logic [frm_pkg::CFG_IDX_W-1:0] REG_SPARE    = 2'd3;
  localparam logic [frm_pkg::MODE_W-1:0]    MODE_SPARE_A = 3'd6;
  localparam logic [frm_pkg::MODE_W-1:0]    MODE_SPARE_B = 3'd7;

  localparam int RAND_ITEMS    = 750;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int N_DIR         = 37;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [frm_pkg::PIX_W-1:0] pix;
    logic                      last;
  } pix_result_t;

  typedef struct packed {
    logic                           is_reg;
    logic [frm_pkg::CFG_IDX_W-1:0]  idx;
    logic [frm_pkg::CFG_DATA_W-1:0] data;
    logic                           req;
    logic [frm_pkg::PIX_W-1:0]      pix;
    logic                           typed;
    logic [frm_pkg::PIX_W-1:0]      exp_pix;
    logic                           exp_last;
  } dir_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           start_i;
  logic                           busy_o;
  logic                           req_type_i;
  logic [frm_pkg::PIX_W-1:0]      pixel_in_i;
  logic                           valid_o;
  logic [frm_pkg::PIX_W-1:0]      pixel_out_o;
  logic                           frame_last_o;
  logic                           cfg_we_i;
  logic [frm_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [frm_pkg::CFG_DATA_W-1:0] cfg_data_i;

  frame_rotate_mirror_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .pixel_in_i  (pixel_in_i),
    .valid_o     (valid_o),
    .pixel_out_o (pixel_out_o),
    .frame_last_o(frame_last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [frm_pkg::PIX_W-1:0]      frame_mem   [0:STORE_SIZE-1];
  bit                             pix_written [0:STORE_SIZE-1];
  int unsigned                    src_row, src_col, out_row, out_col;
  logic [frm_pkg::MODE_W-1:0]     cur_mode;
  logic [frm_pkg::CFG_DATA_W-1:0] cur_w, cur_h;

  pix_result_t pending_pixels[$];
  pix_result_t seen_want;

  int cycle_count     = 0;
  int fail_count      = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int rand_items      = 0;
  int reg_writes      = 0;
  int idle_pct        = 0;

  function automatic int unsigned clamp_dim(input logic [frm_pkg::CFG_DATA_W-1:0] v,
                                            input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic dir_row_t row_write(input logic [frm_pkg::PIX_W-1:0] p);
    dir_row_t r;
    r     = '0;
    r.req = frm_pkg::REQ_WRITE;
    r.pix = p;
    return r;
  endfunction

  function automatic dir_row_t row_read();
    dir_row_t r;
    r     = '0;
    r.req = frm_pkg::REQ_READ;
    return r;
  endfunction

  function automatic dir_row_t row_read_exp(input logic [frm_pkg::PIX_W-1:0] p,
                                            input logic l);
    dir_row_t r;
    r          = '0;
    r.req      = frm_pkg::REQ_READ;
    r.typed    = 1'b1;
    r.exp_pix  = p;
    r.exp_last = l;
    return r;
  endfunction

  function automatic dir_row_t row_reg(input logic [frm_pkg::CFG_IDX_W-1:0] i,
                                       input logic [frm_pkg::CFG_DATA_W-1:0] d);
    dir_row_t r;
    r        = '0;
    r.is_reg = 1'b1;
    r.idx    = i;
    r.data   = d;
    return r;
  endfunction

  function automatic dir_row_t dir_row(input int n);
    case (n)
      0:  return row_write(24'h000000);
      1:  return row_write(24'hFFFFFF);
      2:  return row_read_exp(24'h000000, 1'b0);
      3:  return row_read_exp(24'hFFFFFF, 1'b0);
      // out-of-range index leaves the raster positions alone
      4:  return row_reg(REG_SPARE, 9'h1FF);
      5:  return row_write(24'hA5C30F);
      6:  return row_read_exp(24'hA5C30F, 1'b0);
      7:  return row_reg(frm_pkg::REG_WIDTH, 9'd2);
      8:  return row_reg(frm_pkg::REG_HEIGHT, 9'd2);
      9:  return row_reg(frm_pkg::REG_MODE, {6'b000000, frm_pkg::MODE_ROT180});
      10: return row_write(24'h0000FF);
      11: return row_write(24'h00FF00);
      12: return row_write(24'hFF0000);
      13: return row_write(24'h800001);
      14: return row_read_exp(24'h800001, 1'b0);
      15: return row_read_exp(24'hFF0000, 1'b0);
      16: return row_read_exp(24'h00FF00, 1'b0);
      17: return row_read_exp(24'h0000FF, 1'b1);
      18: return row_reg(frm_pkg::REG_HEIGHT, 9'd1);
      // upper data bits of the mode register are dropped
      19: return row_reg(frm_pkg::REG_MODE, {6'b101010, frm_pkg::MODE_ROT90});
      22: return row_reg(frm_pkg::REG_MODE, {6'b000000, frm_pkg::MODE_ROT270});
      25: return row_reg(frm_pkg::REG_MODE, {6'b000000, frm_pkg::MODE_MIR_H});
      28: return row_reg(frm_pkg::REG_MODE, {6'b000000, frm_pkg::MODE_MIR_V});
      31: return row_reg(frm_pkg::REG_MODE, {6'b000000, MODE_SPARE_A});
      34: return row_reg(frm_pkg::REG_MODE, {6'b000000, MODE_SPARE_B});
      default: return row_read();
    endcase
  endfunction

  task automatic locate_output(output int unsigned addr, output logic last,
                               output int unsigned nrow, output int unsigned ncol);
    int unsigned w, h, ow, oh, r, c, sr, sc;
    w = clamp_dim(cur_w, MAX_W);
    h = clamp_dim(cur_h, MAX_H);
    if (cur_mode == frm_pkg::MODE_ROT90 || cur_mode == frm_pkg::MODE_ROT270) begin
      ow = h;
      oh = w;
    end else begin
      ow = w;
      oh = h;
    end
    r = out_row;
    c = out_col;
    if (r >= oh || c >= ow) begin
      r = 0;
      c = 0;
    end
    case (cur_mode)
      frm_pkg::MODE_ROT90: begin
        sr = c;
        sc = w - 1 - r;
      end
      frm_pkg::MODE_ROT180: begin
        sr = h - 1 - r;
        sc = w - 1 - c;
      end
      frm_pkg::MODE_ROT270: begin
        sr = h - 1 - c;
        sc = r;
      end
      frm_pkg::MODE_MIR_H: begin
        sr = r;
        sc = w - 1 - c;
      end
      frm_pkg::MODE_MIR_V: begin
        sr = h - 1 - r;
        sc = c;
      end
      default: begin
        sr = r;
        sc = c;
      end
    endcase
    addr = (sr * MAX_W + sc) % STORE_SIZE;
    last = (r == oh - 1) && (c == ow - 1);
    if (c + 1 >= ow) begin
      ncol = 0;
      nrow = (r + 1 >= oh) ? 0 : r + 1;
    end else begin
      ncol = c + 1;
      nrow = r;
    end
  endtask

  task automatic transform_item(input logic req, input logic [frm_pkg::PIX_W-1:0] pix,
                                input logic typed,
                                input logic [frm_pkg::PIX_W-1:0] exp_pix,
                                input logic exp_last);
    int unsigned w, h, addr, nrow, ncol;
    logic        last;
    pix_result_t res;
    if (req == frm_pkg::REQ_WRITE) begin
      w = clamp_dim(cur_w, MAX_W);
      h = clamp_dim(cur_h, MAX_H);
      if (src_row >= h || src_col >= w) begin
        src_row = 0;
        src_col = 0;
      end
      addr              = (src_row * MAX_W + src_col) % STORE_SIZE;
      frame_mem[addr]   = pix;
      pix_written[addr] = 1'b1;
      if (src_col + 1 >= w) begin
        src_col = 0;
        src_row = (src_row + 1 >= h) ? 0 : src_row + 1;
      end else begin
        src_col = src_col + 1;
      end
    end else begin
      locate_output(addr, last, nrow, ncol);
      if (typed) begin
        res.pix  = exp_pix;
        res.last = exp_last;
      end else begin
        res.pix  = frame_mem[addr];
        res.last = last;
      end
      pending_pixels.push_back(res);
      out_row = nrow;
      out_col = ncol;
    end
  endtask

  task automatic set_reg(input logic [frm_pkg::CFG_IDX_W-1:0] idx,
                         input logic [frm_pkg::CFG_DATA_W-1:0] data);
    bit hit;
    hit = 1'b1;
    case (idx)
      frm_pkg::REG_MODE:   cur_mode = data[frm_pkg::MODE_W-1:0];
      frm_pkg::REG_WIDTH:  cur_w = data;
      frm_pkg::REG_HEIGHT: cur_h = data;
      default:             hit = 1'b0;
    endcase
    if (hit) begin
      src_row = 0;
      src_col = 0;
      out_row = 0;
      out_col = 0;
    end
  endtask

  task automatic read_ready(output bit ok);
    int unsigned addr, nrow, ncol;
    logic        last;
    locate_output(addr, last, nrow, ncol);
    ok = pix_written[addr];
  endtask

  task automatic send_item(input logic req, input logic [frm_pkg::PIX_W-1:0] pix,
                           input logic typed, input logic [frm_pkg::PIX_W-1:0] exp_pix,
                           input logic exp_last);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) gap = int'($urandom_range(3, 1));
    repeat (gap) begin
      @(posedge clk_i);
      start_i <= 1'b0;
    end
    @(posedge clk_i);
    start_i    <= 1'b1;
    req_type_i <= req;
    pixel_in_i <= pix;
    forever begin
      @(negedge clk_i);
      if (busy_o === 1'b0) break;
    end
    transform_item(req, pix, typed, exp_pix, exp_last);
    items_sent++;
  endtask

  task automatic settle();
    @(posedge clk_i);
    start_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [frm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [frm_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    set_reg(idx, data);
    reg_writes++;
  endtask

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_pixels.size());
      $display("FAIL frame_rotate_mirror_top");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && valid_o === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        report($sformatf("result with no read pending: pixel %06h last %0b",
                         pixel_out_o, frame_last_o));
      end else begin
        seen_want = pending_pixels.pop_front();
        results_checked++;
        if (pixel_out_o !== seen_want.pix)
          report($sformatf("pixel_out expected %06h got %06h", seen_want.pix, pixel_out_o));
        if (frame_last_o !== seen_want.last)
          report($sformatf("frame_last expected %0b got %0b", seen_want.last, frame_last_o));
      end
    end
  end

  initial begin : stimulus
    dir_row_t                       row;
    bit                             ok, prefix, big, wide;
    int                             n, k, ops, phase, rd_pct;
    int unsigned                    area;
    logic [frm_pkg::CFG_DATA_W-1:0] wd, hd;

    rst_ni     = 1'b0;
    start_i    = 1'b0;
    req_type_i = frm_pkg::REQ_WRITE;
    pixel_in_i = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = frm_pkg::REG_MODE;
    cfg_data_i = '0;
    cur_mode   = frm_pkg::MODE_COPY;
    cur_w      = frm_pkg::DIM_RESET;
    cur_h      = frm_pkg::DIM_RESET;
    src_row    = 0;
    src_col    = 0;
    out_row    = 0;
    out_col    = 0;
    wide       = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (n = 0; n < N_DIR; n++) begin
      row = dir_row(n);
      if (row.is_reg) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        send_item(row.req, row.pix, row.typed, row.exp_pix, row.exp_last);
      end
    end

    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      idle_pct = (phase % 4 == 1) ? 66 : (phase % 4 == 3) ? 17 : 0;
      big      = 1'b0;
      prefix   = ($urandom_range(9, 0) < 8);
      case (phase)
        0: begin
          wd = 9'd0;
          hd = 9'd0;
        end
        1: begin
          big    = 1'b1;
          prefix = 1'b1;
          wide   = 1'($urandom_range(1, 0));
          wd     = wide ? 9'd511 : 9'd1;
          hd     = wide ? 9'd1 : 9'd511;
        end
        2: begin
          prefix = 1'b0;
          wd     = wide ? 9'd1 : 9'd256;
          hd     = wide ? 9'd256 : 9'd1;
        end
        default: begin
          wd = frm_pkg::CFG_DATA_W'($urandom_range(8, 1));
          hd = frm_pkg::CFG_DATA_W'($urandom_range(8, 1));
        end
      endcase
      settle();
      write_reg(frm_pkg::REG_MODE, frm_pkg::CFG_DATA_W'($urandom_range(511, 0)));
      write_reg(frm_pkg::REG_WIDTH, wd);
      write_reg(frm_pkg::REG_HEIGHT, hd);
      area = clamp_dim(wd, MAX_W) * clamp_dim(hd, MAX_H);
      if (prefix) begin
        for (k = 0; k < area; k++) begin
          send_item(frm_pkg::REQ_WRITE, frm_pkg::PIX_W'($urandom), 1'b0, '0, 1'b0);
          rand_items++;
        end
      end
      if (big) ops = 48;
      else if (phase == 2) ops = 24;
      else ops = int'(area * $urandom_range(2, 1) + $urandom_range(6, 0));
      rd_pct = big ? 95 : 75;
      for (k = 0; k < ops; k++) begin
        if (k == ops / 2 && $urandom_range(2, 0) == 0) settle();
        ok = 1'b0;
        if ($urandom_range(99, 0) < rd_pct) read_ready(ok);
        send_item(ok ? frm_pkg::REQ_READ : frm_pkg::REQ_WRITE, frm_pkg::PIX_W'($urandom),
                  1'b0, '0, 1'b0);
        rand_items++;
      end
      phase++;
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("sent %0d items (%0d random), checked %0d transformed pixels",
             items_sent, rand_items, results_checked);
    $display("%0d register writes, %0d random mode and geometry settings, all modes",
             reg_writes, phase);
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("PASS frame_rotate_mirror_top");
    end else begin
      $display("%0d mismatches, %0d results never seen", fail_count, pending_pixels.size());
      $display("FAIL frame_rotate_mirror_top");
    end
    $finish;
  end

endmodule
